// File: rtl/box_filter_forward_window_unit_defines.svh
// Assertion macros shared by the box filter RTL.
`ifndef BOX_FILTER_FORWARD_WINDOW_UNIT_DEFINES_SVH
`define BOX_FILTER_FORWARD_WINDOW_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFFW_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bffw: assertion failed");
`define BFFW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bffw: assertion failed");
`else
`define BFFW_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BFFW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/bffw_pkg.sv
// Types, constants and the reciprocal table of the box filter.
package bffw_pkg;

  localparam int PIX_W      = 8;
  localparam int WIN_W      = 4;
  localparam int LINE_W     = 13;
  localparam int LEN_W      = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int COL_SUM_W  = 11;
  localparam int TOTAL_W    = 16;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;

  localparam int MAX_LINE_COUNT = 4096;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd2;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 4'd3;
  localparam logic [LINE_W-1:0] LINE_RESET = 13'd128;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd128;

  typedef struct packed {
    logic              shift;
    logic [WIN_W-1:0]  window;
    logic [LINE_W-1:0] line;
  } bffw_cell_ctl_t;

  // ceil(2^24 / (m*m)): floor(n * recip >> 24) equals n / (m*m) for n below 2^16
  function automatic logic [RECIP_W-1:0] recip_of(input logic [WIN_W-1:0] m);
    logic [RECIP_W-1:0] r;
    unique case (m)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd4194304;
      4'd3:    r = 25'd1864136;
      4'd4:    r = 25'd1048576;
      4'd5:    r = 25'd671089;
      4'd6:    r = 25'd466034;
      4'd7:    r = 25'd342393;
      4'd8:    r = 25'd262144;
      4'd9:    r = 25'd207127;
      4'd10:   r = 25'd167773;
      4'd11:   r = 25'd138655;
      4'd12:   r = 25'd116509;
      4'd13:   r = 25'd99274;
      4'd14:   r = 25'd85599;
      default: r = 25'd74566;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bffw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bffw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1031,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

// File: rtl/bffw_line_cell.sv
// One line-delay cell: holds one past line and adds its tap to the column sum.
module bffw_line_cell #(
  parameter int TAP    = 1,
  parameter int DEPTH  = 1031,
  parameter int ADDR_W = 11
) (
  input  logic                              clk,
  input  bffw_pkg::bffw_cell_ctl_t          ctl,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic [bffw_pkg::PIX_W-1:0]        pass_in,
  input  logic [bffw_pkg::COL_SUM_W-1:0]    sum_in,
  output logic [bffw_pkg::PIX_W-1:0]        pass_out,
  output logic [bffw_pkg::COL_SUM_W-1:0]    sum_out
);
  import bffw_pkg::*;

  logic [PIX_W-1:0] tap_q;
  logic             tap_use;

  // hold the line TAP lines back; write what the upstream cell held
  bffw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctl.shift),
    .wr_addr(wr_addr),
    .wr_data(pass_in),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(tap_q)
  );

  // use the tap only inside the window and once that line exists in the frame
  assign tap_use  = (TAP < int'(ctl.window)) && (TAP <= int'(ctl.line));
  assign pass_out = tap_q;
  assign sum_out  = sum_in + (tap_use ? COL_SUM_W'(tap_q) : COL_SUM_W'(0));

endmodule

// File: rtl/box_filter_forward_window_unit.sv
// Top level of the streaming m-by-m forward-window box mean filter.
// A result passes the stage 1, 2 and 3 registers and the output queue before it is shown.
// Throughput: one item per cycle while the eight-entry output queue has credit.
// Reset: clears positions, column sums, pipeline and queue; registers go to 3/128/128.
// The line store in the cell chain is not cleared; it is written before any read is used.
`include "box_filter_forward_window_unit_defines.svh"
module box_filter_forward_window_unit #(
  parameter int MAX_WINDOW      = 8,
  parameter int MAX_LINE_LENGTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bffw_pkg::PIX_W-1:0]      in_pixel_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bffw_pkg::PIX_W-1:0]      out_filtered_value,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bffw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bffw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bffw_pkg::*;

  localparam int NCELL  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int DEPTH  = MAX_LINE_LENGTH + MAX_WINDOW - 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_LINE_LENGTH + MAX_WINDOW);
  localparam int PROD_W = TOTAL_W + RECIP_W;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] value;
  } out_item_t;

  // configuration registers
  logic [WIN_W-1:0]  win_r;
  logic [LINE_W-1:0] lines_cfg_r;
  logic [LEN_W-1:0]  len_cfg_r;
  logic              cfg_hit;

  // clamped frame geometry
  logic [WIN_W-1:0]  m_eff;
  logic [LINE_W-1:0] lines_eff;
  logic [COL_W-1:0]  width_eff;
  logic [LINE_W-1:0] padded_lines;
  logic [COL_W-1:0]  padded_width;

  // frame position of the next item
  logic [LINE_W-1:0] line_pos_r;
  logic [COL_W-1:0]  col_pos_r;
  logic [LINE_W-1:0] line_pos_nxt;
  logic [COL_W-1:0]  col_pos_nxt;

  // entry stage
  logic              in_accept;
  logic              pad0;
  logic [PIX_W-1:0]  v0;
  logic              out_en0;
  logic              last0;

  // stage 1: line store read data arrives
  logic              valid_s1_r;
  logic [PIX_W-1:0]  v_s1_r;
  logic [COL_W-1:0]  c_s1_r;
  logic [LINE_W-1:0] r_s1_r;
  logic              out_en_s1_r;
  logic              last_s1_r;

  // stage 2: column sums updated
  logic [COL_SUM_W-1:0] col_sums_r [MAX_WINDOW];
  logic                 valid_s2_r;
  logic                 last_s2_r;
  logic [TOTAL_W-1:0]   total;

  // stage 3: window total, then divide by m*m
  logic                 valid_s3_r;
  logic                 last_s3_r;
  logic [TOTAL_W-1:0]   total_s3_r;
  logic [PROD_W-1:0]    product;
  logic [PIX_W-1:0]     quotient;

  // cell chain
  bffw_cell_ctl_t       cell_ctl;
  logic [PIX_W-1:0]     pass_w [NCELL+1];
  logic [COL_SUM_W-1:0] sum_w  [NCELL+1];

  // output queue
  out_item_t             fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_count_r;
  logic [FIFO_CNT_W-1:0] occupancy;
  logic                  push;
  logic                  pop;
  out_item_t             head;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; a write to a known register restarts the frame
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_WINDOW_SIZE || cfg_index == CFG_LINE_COUNT ||
                      cfg_index == CFG_LINE_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      lines_cfg_r <= LINE_RESET;
      len_cfg_r   <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: win_r       <= cfg_data[WIN_W-1:0];
        CFG_LINE_COUNT:  lines_cfg_r <= cfg_data[LINE_W-1:0];
        CFG_LINE_LENGTH: len_cfg_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers: zero counts as one, oversize counts as the maximum
  always_comb begin
    if (win_r == '0) begin
      m_eff = WIN_W'(1);
    end else if (int'(win_r) > MAX_WINDOW) begin
      m_eff = WIN_W'(MAX_WINDOW);
    end else begin
      m_eff = win_r;
    end

    if (lines_cfg_r == '0) begin
      lines_eff = LINE_W'(1);
    end else if (int'(lines_cfg_r) > MAX_LINE_COUNT) begin
      lines_eff = LINE_W'(MAX_LINE_COUNT);
    end else begin
      lines_eff = lines_cfg_r;
    end

    if (len_cfg_r == '0) begin
      width_eff = COL_W'(1);
    end else if (int'(len_cfg_r) > MAX_LINE_LENGTH) begin
      width_eff = COL_W'(MAX_LINE_LENGTH);
    end else begin
      width_eff = COL_W'(len_cfg_r);
    end

    padded_lines = lines_eff + LINE_W'(m_eff) - LINE_W'(1);
    padded_width = width_eff + COL_W'(m_eff) - COL_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Entry: accept on credit, zero padding pixels, advance the raster position
  // ---------------------------------------------------------------------------
  assign occupancy = fifo_count_r + FIFO_CNT_W'(valid_s1_r && out_en_s1_r)
                   + FIFO_CNT_W'(valid_s2_r) + FIFO_CNT_W'(valid_s3_r);
  assign in_ready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_accept = in_valid && in_ready;

  always_comb begin
    pad0    = (line_pos_r >= lines_eff) || (col_pos_r >= width_eff);
    v0      = pad0 ? '0 : in_pixel_value;
    // window is complete once m-1 lines and m-1 columns lie behind this item
    out_en0 = (line_pos_r >= LINE_W'(m_eff - WIN_W'(1))) &&
              (col_pos_r >= COL_W'(m_eff - WIN_W'(1)));
    last0   = (line_pos_r == padded_lines - LINE_W'(1)) &&
              (col_pos_r == padded_width - COL_W'(1));

    col_pos_nxt  = col_pos_r + COL_W'(1);
    line_pos_nxt = line_pos_r;
    if (col_pos_nxt >= padded_width) begin
      col_pos_nxt  = '0;
      line_pos_nxt = line_pos_r + LINE_W'(1);
      if (line_pos_nxt >= padded_lines) begin
        line_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r <= '0;
      col_pos_r  <= '0;
    end else if (cfg_hit) begin
      line_pos_r <= '0;
      col_pos_r  <= '0;
    end else if (in_accept) begin
      line_pos_r <= line_pos_nxt;
      col_pos_r  <= col_pos_nxt;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s1_r <= 1'b0;
    end else begin
      valid_s1_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      v_s1_r      <= v0;
      c_s1_r      <= col_pos_r;
      r_s1_r      <= line_pos_r;
      out_en_s1_r <= out_en0;
      last_s1_r   <= last0;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: every cell reads its line at the entry column, and in stage 1
  // each cell takes over its upstream neighbour's pixel while the partial
  // column sum ripples down the row of cells.
  // ---------------------------------------------------------------------------
  assign cell_ctl.shift  = valid_s1_r;
  assign cell_ctl.window = m_eff;
  assign cell_ctl.line   = r_s1_r;

  assign pass_w[0] = v_s1_r;
  assign sum_w[0]  = COL_SUM_W'(v_s1_r);

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    bffw_line_cell #(
      .TAP   (k),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .rd_en   (in_accept),
      .rd_addr (col_pos_r[ADDR_W-1:0]),
      .wr_addr (c_s1_r[ADDR_W-1:0]),
      .pass_in (pass_w[k-1]),
      .sum_in  (sum_w[k-1]),
      .pass_out(pass_w[k]),
      .sum_out (sum_w[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 2: shift the column sums, drop items whose window is not complete
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        col_sums_r[k] <= '0;
      end
    end else if (valid_s1_r) begin
      col_sums_r[0] <= sum_w[NCELL];
      for (int k = 1; k < MAX_WINDOW; k++) begin
        col_sums_r[k] <= col_sums_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s2_r <= 1'b0;
      valid_s3_r <= 1'b0;
    end else begin
      valid_s2_r <= valid_s1_r && out_en_s1_r;
      valid_s3_r <= valid_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    last_s2_r <= last_s1_r;
    last_s3_r <= last_s2_r;
  end

  // Window total over the m newest column sums
  always_comb begin
    total = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (k < int'(m_eff)) begin
        total = total + TOTAL_W'(col_sums_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_s2_r) begin
      total_s3_r <= total;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by m*m through the reciprocal table, push into the queue
  // ---------------------------------------------------------------------------
  assign product  = PROD_W'(total_s3_r) * PROD_W'(recip_of(m_eff));
  assign quotient = product[RECIP_SHIFT +: PIX_W];

  assign push = valid_s3_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= '{last: last_s3_r, value: quotient};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      fifo_count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      fifo_count_r <= fifo_count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  assign head               = fifo_mem_r[rd_ptr_r];
  assign out_valid          = (fifo_count_r != '0);
  assign out_filtered_value = head.value;
  assign out_frame_last     = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BFFW_ASSERT_IMP(a_credit_bound, clk, rst_n, 1'b1, occupancy <= FIFO_CNT_W'(FIFO_DEPTH))
  `BFFW_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, fifo_count_r < FIFO_CNT_W'(FIFO_DEPTH) || pop)
  `BFFW_ASSERT_NEXT(a_push_shows_item, clk, rst_n, push, out_valid)
  `BFFW_ASSERT_IMP(a_col_in_frame, clk, rst_n, 1'b1, col_pos_r < padded_width)
  `BFFW_ASSERT_NEXT(a_frame_wraps, clk, rst_n, in_accept && last0, line_pos_r == '0 && col_pos_r == '0)

endmodule
